// ===== sv/next_fit_id_allocator_macros.svh =====
// Assertion macros shared by the identifier allocator RTL.
// Depends on nothing; each use expects signals named clk and rst_n in scope.
`ifndef NEXT_FIT_ID_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_ID_ALLOCATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define NFIA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define NFIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nfia_pkg.sv =====
// Shared types, codes and helpers for the next-fit identifier allocator.
// Depends on nothing; used by the top level and the bench.
`default_nettype none

package nfia_pkg;

  // Bitmap word geometry
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  typedef logic [WORD_W-1:0] word_t;

  // Request codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Index of the lowest set bit of a word (zero when none is set)
  function automatic logic [OFF_W-1:0] lowest_set(input word_t w);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = OFF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nfia_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module nfia_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/next_fit_id_allocator.sv =====
// Top level of the next-fit identifier allocator: sequencer around a bitmap RAM.
// Depends on nfia_pkg, nfia_ram and next_fit_id_allocator_macros.svh.
//
//   channel | direction | handshake           | fields
//   in_     | input     | in_valid / in_stall   | in_command, in_release_id
//   out_    | output    | out_valid / out_stall | out_ok, out_granted_id
//
// The bitmap lives in a RAM of 32-bit words with one read port and registered read data.
// Allocate reads and checks one word at a time from the start word until a free bit or the wrap;
// release reads one word and writes it back; allocate while full and a bad release go straight to the reply.
// After reset a clearing pass zeroes the bitmap, one word a cycle: ceil(ID_COUNT/32)
// words (8 at the default), with in_stall high throughout.
// A finished word waits in the output register; a new request is taken meanwhile.
`default_nettype none

`include "next_fit_id_allocator_macros.svh"

module next_fit_id_allocator #(
  parameter int ID_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_release_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [7:0] out_granted_id
);

  localparam int WORD_W    = nfia_pkg::WORD_W;
  localparam int OFF_W     = nfia_pkg::OFF_W;
  localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FULL_W    = WADDR_W + OFF_W;
  localparam int PTR_W     = $clog2(ID_COUNT);
  localparam int CNT_W     = $clog2(WORDS + 1);
  localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_W;

  localparam nfia_pkg::word_t ONES      = '1;
  localparam nfia_pkg::word_t LAST_MASK = ONES >> (WORD_W - LAST_BITS);

  nfia_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               full_r, full_nxt;
  logic               cmd_r, cmd_nxt;
  logic [WADDR_W-1:0] cur_r, cur_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WADDR_W-1:0] clr_r, clr_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [7:0]         res_id_r, res_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [7:0]         out_id_r, out_id_nxt;

  logic               ram_we, ram_re;
  logic [WADDR_W-1:0] ram_waddr;
  nfia_pkg::word_t    ram_wdata, ram_rdata;

  logic [PTR_W-1:0]   ptr_adv;
  logic [FULL_W-1:0]  start_full;
  logic               rel_ok;
  logic               out_free;
  logic               in_fire;
  nfia_pkg::word_t    pass_mask, free_w;
  logic               hit;
  logic [OFF_W-1:0]   hit_bit;
  logic [FULL_W-1:0]  hit_id;
  logic [WADDR_W-1:0] cur_next_word;

  // Bitmap storage
  nfia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .ADDR_W(WADDR_W)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(cur_r),
    .rdata(ram_rdata)
  );

  // Pointer advance and split of the scan start into word and bit
  assign ptr_adv    = (ptr_r == PTR_W'(ID_COUNT - 1)) ? '0 : ptr_r + 1'b1;
  assign start_full = FULL_W'(ptr_adv);
  assign rel_ok     = (in_release_id != 8'd0) && (32'(in_release_id) < ID_COUNT);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_fire    = in_valid && !in_stall;

  // Mask the word under scan: start bits first, wrapped bits last, padding never
  always_comb begin
    pass_mask = ONES;
    if (cnt_r == '0) begin
      pass_mask = ONES << off_r;
    end else if (cnt_r == CNT_W'(WORDS)) begin
      pass_mask = ~(ONES << off_r);
    end
    if (cur_r == WADDR_W'(WORDS - 1)) begin
      pass_mask = pass_mask & LAST_MASK;
    end
  end

  assign free_w        = ~ram_rdata & pass_mask;
  assign hit           = |free_w;
  assign hit_bit       = nfia_pkg::lowest_set(free_w);
  assign hit_id        = {cur_r, hit_bit};
  assign cur_next_word = (cur_r == WADDR_W'(WORDS - 1)) ? '0 : cur_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfia_pkg::ST_CLEAR: begin
        if (clr_r == WADDR_W'(WORDS - 1)) begin
          state_nxt = nfia_pkg::ST_IDLE;
        end
      end
      nfia_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_command == nfia_pkg::CMD_ALLOC && full_r) ||
              (in_command == nfia_pkg::CMD_RELEASE && !rel_ok)) begin
            state_nxt = nfia_pkg::ST_DONE;
          end else begin
            state_nxt = nfia_pkg::ST_READ;
          end
        end
      end
      nfia_pkg::ST_READ: begin
        state_nxt = nfia_pkg::ST_CHECK;
      end
      nfia_pkg::ST_CHECK: begin
        if (cmd_r == nfia_pkg::CMD_RELEASE || hit || cnt_r == CNT_W'(WORDS)) begin
          state_nxt = nfia_pkg::ST_DONE;
        end else begin
          state_nxt = nfia_pkg::ST_READ;
        end
      end
      nfia_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = nfia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nfia_pkg::ST_CLEAR;
      end
    endcase
  end

  // Handshake and RAM port outputs
  always_comb begin
    in_stall  = (state_r != nfia_pkg::ST_IDLE);
    ram_re    = (state_r == nfia_pkg::ST_READ);
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = ram_rdata | (nfia_pkg::word_t'(1) << hit_bit);
    unique case (state_r)
      nfia_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      nfia_pkg::ST_CHECK: begin
        if (cmd_r == nfia_pkg::CMD_RELEASE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(nfia_pkg::word_t'(1) << off_r);
        end else begin
          ram_we = hit;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath register updates
  always_comb begin
    ptr_nxt       = ptr_r;
    full_nxt      = full_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nfia_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
      end
      nfia_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          res_ok_nxt = 1'b0;
          res_id_nxt = 8'd0;
          if (in_command == nfia_pkg::CMD_ALLOC) begin
            if (!full_r) begin
              ptr_nxt = ptr_adv;
              cur_nxt = start_full[FULL_W-1:OFF_W];
              off_nxt = start_full[OFF_W-1:0];
              cnt_nxt = '0;
            end
          end else begin
            cur_nxt = WADDR_W'(in_release_id[7:OFF_W]);
            off_nxt = in_release_id[OFF_W-1:0];
          end
        end
      end
      nfia_pkg::ST_CHECK: begin
        if (cmd_r == nfia_pkg::CMD_RELEASE) begin
          full_nxt   = 1'b0;
          res_ok_nxt = 1'b1;
        end else if (hit) begin
          ptr_nxt    = PTR_W'(hit_id);
          res_ok_nxt = 1'b1;
          res_id_nxt = 8'(hit_id);
        end else if (cnt_r == CNT_W'(WORDS)) begin
          full_nxt = 1'b1;
        end else begin
          cur_nxt = cur_next_word;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nfia_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_id_nxt    = res_id_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfia_pkg::ST_CLEAR;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      full_r      <= full_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    cur_r    <= cur_nxt;
    off_r    <= off_nxt;
    cnt_r    <= cnt_nxt;
    res_ok_r <= res_ok_nxt;
    res_id_r <= res_id_nxt;
    out_ok_r <= out_ok_nxt;
    out_id_r <= out_id_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_granted_id = out_id_r;

  // Assertions
  `NFIA_ASSERT_IMPLIES(a_grant_in_range, state_r == nfia_pkg::ST_CHECK && cmd_r == nfia_pkg::CMD_ALLOC && hit, 32'(hit_id) < ID_COUNT, "granted identifier beyond table")
  `NFIA_ASSERT_IMPLIES(a_scan_bounded, state_r == nfia_pkg::ST_CHECK, cnt_r <= CNT_W'(WORDS), "scan ran past the wrapped start word")
  `NFIA_ASSERT_NEXT(a_fail_keeps_ptr, state_r == nfia_pkg::ST_CHECK && cmd_r == nfia_pkg::CMD_ALLOC && !hit && cnt_r == CNT_W'(WORDS), full_r && $stable(ptr_r), "exhaustive scan moved pointer or left table not full")
  `NFIA_ASSERT_NEXT(a_result_not_lost, state_r == nfia_pkg::ST_DONE && out_valid_r && out_stall, state_r == nfia_pkg::ST_DONE, "result left while output register busy")
  `NFIA_ASSERT_NEXT(a_accept_busy, in_fire, in_stall, "request taken without entering work")

endmodule

`default_nettype wire

// ===== bench/tb_next_fit_id_allocator.sv =====
// Self-checking bench for next_fit_id_allocator: random and directed requests
// against a bitmap predictor. Depends on nfia_pkg and the next_fit_id_allocator RTL.
`default_nettype none

module tb_next_fit_id_allocator;

  localparam int ID_COUNT = 256;

  typedef struct packed {
    logic       ok;
    logic [7:0] id;
  } grant_word_t;

  // Mirror of the allocator state; predicts each reply word and checks it in order
  class id_grant_scoreboard;
    logic [ID_COUNT-1:0] used_map;
    logic [7:0]          next_ptr;
    logic                full_flag;
    grant_word_t         grant_q[$];
    int                  mismatches;
    int                  replies_seen;

    function new();
      used_map     = '0;
      next_ptr     = '0;
      full_flag    = 1'b0;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Advance the state for one accepted request and queue its reply
    function void note_request(logic cmd, logic [7:0] rel_id);
      grant_word_t g;
      logic [7:0]  start;
      logic        found;
      g = '0;
      found = 1'b0;
      if (cmd == nfia_pkg::CMD_ALLOC) begin
        if (!full_flag) begin
          next_ptr = 8'((int'(next_ptr) + 1) % ID_COUNT);
          start = next_ptr;
          for (int k = 0; k < ID_COUNT && !found; k++) begin
            if (!used_map[next_ptr]) begin
              used_map[next_ptr] = 1'b1;
              g.ok = 1'b1;
              g.id = next_ptr;
              found = 1'b1;
            end else begin
              next_ptr = 8'((int'(next_ptr) + 1) % ID_COUNT);
            end
          end
          // Scan found nothing: rest the pointer where it began and mark full
          if (!found) begin
            next_ptr = start;
            full_flag = 1'b1;
          end
        end
      end else if (rel_id != 8'd0 && int'(rel_id) < ID_COUNT) begin
        used_map[rel_id] = 1'b0;
        full_flag = 1'b0;
        g.ok = 1'b1;
      end
      grant_q.insert(grant_q.size(), g);
    endfunction

    // Compare one accepted reply word with the oldest prediction
    function void check_result(logic ok, logic [7:0] id);
      grant_word_t g;
      if (grant_q.size() == 0) begin
        flag($sformatf("unexpected reply: ok=%b id=%0d", ok, id));
        return;
      end
      g = grant_q.pop_front();
      replies_seen++;
      if (g.ok !== ok) begin
        flag($sformatf("reply %0d: ok expected %b got %b", replies_seen, g.ok, ok));
      end
      if (g.id !== id) begin
        flag($sformatf("reply %0d: granted_id expected %0d got %0d", replies_seen, g.id, id));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_command;
  logic [7:0] in_release_id;
  logic       out_valid;
  logic       out_stall;
  logic       out_ok;
  logic [7:0] out_granted_id;
  logic       quiet_phase;
  logic       long_hold_done;

  id_grant_scoreboard sb = new();

  next_fit_id_allocator #(.ID_COUNT(ID_COUNT)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_release_id (in_release_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_granted_id(out_granted_id)
  );

  // Clock: period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one request word, optionally after a gap, and hold it until taken
  task automatic send_word(input logic cmd, input logic [7:0] rel_id, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_release_id <= rel_id;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    sb.note_request(cmd, rel_id);
    @(negedge clk);
  endtask

  // Hold the input low until every reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.pending() > 0) begin
      @(negedge clk);
    end
  endtask

  // Take reply words at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_ok, out_granted_id);
    end
  end

  // Receiver: random stalls, one long hold-off, none in the quiet phase
  initial begin
    int n;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb.replies_seen >= 150) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_phase) begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int alloc_pct[8];
    int gap;
    logic cmd;
    alloc_pct = '{97, 97, 97, 25, 70, 95, 95, 50};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = nfia_pkg::CMD_ALLOC;
    in_release_id = 8'd0;
    quiet_phase   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first grants, refused release of zero, edge ids, release of a free slot
    send_word(nfia_pkg::CMD_ALLOC,   8'hFF, 0);
    send_word(nfia_pkg::CMD_ALLOC,   8'h00, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd0,  0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd255, pick_gap());
    send_word(nfia_pkg::CMD_RELEASE, 8'd2,  0);
    send_word(nfia_pkg::CMD_ALLOC,   8'hAA, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd1,  pick_gap());
    send_word(nfia_pkg::CMD_ALLOC,   8'h55, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'hAA, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'h55, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'h80, pick_gap());
    send_word(nfia_pkg::CMD_RELEASE, 8'h7F, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd1,  0);
    send_word(nfia_pkg::CMD_ALLOC,   8'h0F, 0);
    send_word(nfia_pkg::CMD_ALLOC,   8'hF0, pick_gap());
    send_word(nfia_pkg::CMD_ALLOC,   8'h01, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd254, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd3,  0);
    send_word(nfia_pkg::CMD_ALLOC,   8'h80, 0);
    send_word(nfia_pkg::CMD_RELEASE, 8'd0,  pick_gap());

    // Pause until the directed replies are all back
    drain_replies();

    // Random: alloc-heavy stretches fill the table to exercise the full paths,
    // a release-heavy one frees identifiers again; one stretch runs without idling
    for (int seg = 0; seg < 8; seg++) begin
      quiet_phase = (seg == 4);
      for (int i = 0; i < 100; i++) begin
        cmd = ($urandom_range(0, 99) < alloc_pct[seg]) ? nfia_pkg::CMD_ALLOC
                                                        : nfia_pkg::CMD_RELEASE;
        gap = quiet_phase ? 0 : pick_gap();
        send_word(cmd, 8'($urandom_range(0, 255)), gap);
      end
    end
    quiet_phase = 1'b0;

    // Drain, then allow for a worst-case allocate scan
    drain_replies();
    repeat (24) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[next_fit_id_allocator] OK");
    end else begin
      $display("[next_fit_id_allocator] ERROR");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #5000000;
    $display("[next_fit_id_allocator] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/nfia_pkg.sv
sv/nfia_ram.sv
sv/next_fit_id_allocator.sv
bench/tb_next_fit_id_allocator.sv
